// ===== hdl/owm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // width of the phase tick counter; lengths are taken modulo 2^TickW
  localparam int unsigned TickW = 10;
  // width of a length register
  localparam int unsigned CfgW = 10;
  // width of the register index on the configuration channel
  localparam int unsigned CfgIdxW = 3;
  // stream payload widths (fields padded to whole bytes)
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  typedef logic [TickW-1:0] tick_t;
  typedef logic [CfgW-1:0]  len_t;

  // register indexes of the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_SLOT_SHORT    = 3'd2,
    REG_SLOT_LONG     = 3'd3,
    REG_READ_LOW      = 3'd4,
    REG_READ_RECOVERY = 3'd5
  } reg_idx_e;

  // commands carried in an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // running operation
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // phase inside an operation or a slot
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SAMPLE = 2'd2,
    PH_SECOND = 2'd3
  } phase_e;

  // reset values of the length registers
  localparam len_t ResetLowDefault     = len_t'(600);
  localparam len_t PresenceWaitDefault = len_t'(453);
  localparam len_t SlotShortDefault    = len_t'(7);
  localparam len_t SlotLongDefault     = len_t'(58);
  localparam len_t ReadLowDefault      = len_t'(13);
  localparam len_t ReadRecoveryDefault = len_t'(60);

  // timing registers handed to the sequencer
  typedef struct packed {
    len_t reset_low;
    len_t presence_wait;
    len_t slot_short;
    len_t slot_long;
    len_t read_low;
    len_t read_recovery;
  } timing_t;

  // decoded input beat
  typedef struct packed {
    cmd_e       command;
    logic [7:0] write_data;
    logic       bus_level;
  } item_t;

  // one result beat
  typedef struct packed {
    logic       rejected;
    logic       device_present;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/owm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file written over the configuration channel.
// ----------------------------------------------------------------------------
module owm_cfg (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [owm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [owm_pkg::CfgW-1:0]      cfg_data_i,
  output owm_pkg::timing_t             timing_o
);
  import owm_pkg::*;

  timing_t timing_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign timing_o    = timing_q;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.reset_low     <= ResetLowDefault;
      timing_q.presence_wait <= PresenceWaitDefault;
      timing_q.slot_short    <= SlotShortDefault;
      timing_q.slot_long     <= SlotLongDefault;
      timing_q.read_low      <= ReadLowDefault;
      timing_q.read_recovery <= ReadRecoveryDefault;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RESET_LOW:     timing_q.reset_low     <= cfg_data_i;
        REG_PRESENCE_WAIT: timing_q.presence_wait <= cfg_data_i;
        REG_SLOT_SHORT:    timing_q.slot_short    <= cfg_data_i;
        REG_SLOT_LONG:     timing_q.slot_long     <= cfg_data_i;
        REG_READ_LOW:      timing_q.read_low      <= cfg_data_i;
        REG_READ_RECOVERY: timing_q.read_recovery <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/owm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_seq
// Bus sequencer: advances reset, byte write and byte read by one tick per beat.
// ----------------------------------------------------------------------------
module owm_seq (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      step_i,
  input  wire owm_pkg::item_t      item_i,
  input  wire owm_pkg::timing_t    timing_i,
  output owm_pkg::result_t         result_o
);
  import owm_pkg::*;

  phase_e     phase_q, phase_d;
  op_e        op_q, op_d;
  tick_t      cnt_q, cnt_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic       first_smp_q, first_smp_d;
  logic       present_q, present_d;
  logic [7:0] last_read_q, last_read_d;

  // state as seen after a possible start
  phase_e     ph;
  op_e        op;
  tick_t      cnt;
  logic [2:0] bi;
  logic [7:0] sb;
  tick_t      cnt_inc;
  tick_t      len;
  logic       reached;
  logic       start;
  logic       drive;
  logic       done;

  // state registers, updated once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      op_q        <= OP_NONE;
      cnt_q       <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      first_smp_q <= 1'b1;
      present_q   <= 1'b0;
      last_read_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
      first_smp_q <= first_smp_d;
      present_q   <= present_d;
      last_read_q <= last_read_d;
    end
  end

  // start of a new operation only when idle
  always_comb begin
    start = (item_i.command != CMD_TICK) && (phase_q == PH_IDLE);
    if (start) begin
      ph  = PH_FIRST;
      op  = op_e'(item_i.command);
      cnt = '0;
      bi  = '0;
      sb  = (item_i.command == CMD_WRITE) ? item_i.write_data : 8'h00;
    end else begin
      ph  = phase_q;
      op  = op_q;
      cnt = cnt_q;
      bi  = bit_idx_q;
      sb  = shift_q;
    end
  end

  // length of the current phase and its end
  always_comb begin
    len = tick_t'(timing_i.reset_low);
    unique case (op)
      OP_RESET: len = (ph == PH_FIRST) ? tick_t'(timing_i.reset_low)
                                       : tick_t'(timing_i.presence_wait);
      OP_WRITE: begin
        if ((ph == PH_FIRST) == sb[0]) len = tick_t'(timing_i.slot_short);
        else                           len = tick_t'(timing_i.slot_long);
      end
      OP_READ:  len = (ph == PH_FIRST) ? tick_t'(timing_i.read_low)
                                       : tick_t'(timing_i.read_recovery);
      OP_NONE:  len = tick_t'(timing_i.reset_low);
    endcase
    cnt_inc = cnt + tick_t'(1);
    reached = (cnt_inc >= len);
  end

  // one tick of the running operation
  always_comb begin
    phase_d     = ph;
    op_d        = op;
    cnt_d       = cnt;
    bit_idx_d   = bi;
    shift_d     = sb;
    first_smp_d = first_smp_q;
    present_d   = present_q;
    last_read_d = last_read_q;
    drive       = 1'b0;
    done        = 1'b0;

    if (ph != PH_IDLE) begin
      unique case (op)
        OP_RESET: begin
          unique case (ph)
            PH_FIRST: begin
              drive = 1'b1;
              cnt_d = cnt_inc;
              if (reached) begin
                phase_d = PH_SAMPLE;
                cnt_d   = '0;
              end
            end
            PH_SAMPLE: begin
              first_smp_d = item_i.bus_level;
              phase_d     = PH_SECOND;
              cnt_d       = '0;
            end
            default: begin
              cnt_d = cnt_inc;
              if (reached) begin
                present_d = !first_smp_q && item_i.bus_level;
                done      = 1'b1;
              end
            end
          endcase
        end
        OP_WRITE: begin
          cnt_d = cnt_inc;
          if (ph == PH_FIRST) begin
            drive = 1'b1;
            if (reached) begin
              phase_d = PH_SECOND;
              cnt_d   = '0;
            end
          end else if (reached) begin
            shift_d = {1'b0, sb[7:1]};
            if (bi == 3'd7) begin
              done = 1'b1;
            end else begin
              bit_idx_d = bi + 3'd1;
              phase_d   = PH_FIRST;
              cnt_d     = '0;
            end
          end
        end
        OP_READ: begin
          unique case (ph)
            PH_FIRST: begin
              drive = 1'b1;
              cnt_d = cnt_inc;
              if (reached) begin
                phase_d = PH_SAMPLE;
                cnt_d   = '0;
              end
            end
            PH_SAMPLE: begin
              shift_d = {item_i.bus_level, sb[7:1]};
              phase_d = PH_SECOND;
              cnt_d   = '0;
            end
            default: begin
              cnt_d = cnt_inc;
              if (reached) begin
                if (bi == 3'd7) begin
                  last_read_d = sb;
                  done        = 1'b1;
                end else begin
                  bit_idx_d = bi + 3'd1;
                  phase_d   = PH_FIRST;
                  cnt_d     = '0;
                end
              end
            end
          endcase
        end
        OP_NONE: done = 1'b1;
      endcase

      // back to idle after the last tick
      if (done) begin
        phase_d   = PH_IDLE;
        op_d      = OP_NONE;
        cnt_d     = '0;
        bit_idx_d = '0;
      end
    end
  end

  // result of this beat
  always_comb begin
    result_o.drive_low      = drive;
    result_o.busy_res       = (ph != PH_IDLE);
    result_o.done_res       = done;
    result_o.read_data      = last_read_d;
    result_o.device_present = present_d;
    result_o.rejected       = (item_i.command != CMD_TICK) && (phase_q != PH_IDLE);
  end

endmodule
`default_nettype wire

// ===== hdl/one_wire_bus_master_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// Single-wire bus master, one input beat per microsecond tick.
// Result: a result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless the result stream stalls; the
// sequencer state and the result register both update in the accepting cycle.
// Reset: asynchronous active low; sequencer idle, timing registers at their
// defaults, output register empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // input stream
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // command [1:0], write_data [9:2], bus_level [10], zero [15:11]
  input  wire [owm_pkg::InDataW-1:0]    s_axis_tdata_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // drive_low [0], busy_res [1], done_res [2], read_data [10:3],
  // device_present [11], rejected [12], zero [15:13]
  output logic [owm_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // configuration write channel
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [owm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [owm_pkg::CfgW-1:0]       cfg_data_i
);
  import owm_pkg::*;

  timing_t timing;
  item_t   item;
  result_t result;
  logic    accept;
  logic    out_valid_q;
  result_t out_q;

  owm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timing_o    (timing)
  );

  // unpack the input beat
  assign item.command    = cmd_e'(s_axis_tdata_i[1:0]);
  assign item.write_data = s_axis_tdata_i[9:2];
  assign item.bus_level  = s_axis_tdata_i[10];

  // take a beat whenever the result register is free or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  owm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (item),
    .timing_i (timing),
    .result_o (result)
  );

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

endmodule
`default_nettype wire

// ===== hdl/owm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks of the single-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owm_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid_i,
  input wire                          s_axis_tready_o,
  input wire                          m_axis_tvalid_o,
  input wire                          m_axis_tready_i,
  input wire [owm_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import owm_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // input side stalls only behind a stalled result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled with result register free");

  // an accepted beat always yields a result beat next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  // completion and line drive happen only inside an operation
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2] || m_axis_tdata_o[0]) |-> m_axis_tdata_o[1])
    else $error("done or drive without busy");

endmodule

bind one_wire_bus_master_top owm_checker u_owm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
